@@ rtl/ssi_pkg.sv @@
`default_nettype none

package ssi_pkg;

    // key width and result field widths
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned COUNT_W  = 7;

    typedef logic signed [KEY_W-1:0] t_key;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_FULL     = 3'd2,
        ST_FOUND    = 3'd3,
        ST_ABSENT   = 3'd4
    } t_status;

    // control from the top level to every cell
    typedef struct packed {
        logic cmp;
        logic shift;
    } t_cell_ctl;

    // what a cell hands to its upper neighbor
    typedef struct packed {
        t_key entry;
        logic lt;
    } t_cell_link;

endpackage

`default_nettype wire

@@ rtl/ssi_cell.sv @@
`default_nettype none

module ssi_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ssi_pkg::t_cell_ctl  i_ctl,
    input  ssi_pkg::t_key       i_cmp_key,
    input  ssi_pkg::t_key       i_ins_key,
    input  wire                 i_occupied,
    input  ssi_pkg::t_cell_link i_prev,
    output ssi_pkg::t_cell_link o_link,
    output logic                o_eq
);

    ssi_pkg::t_key r_entry;
    ssi_pkg::t_key n_entry;
    logic          r_lt;
    logic          r_eq;

    // compare flags, taken when an item is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_occupied && (r_entry < i_cmp_key);
            r_eq <= i_occupied && (r_entry == i_cmp_key);
        end
    end

    // cells at and above the insert point take the key or the lower entry
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.shift && !r_lt) begin
            n_entry = i_prev.lt ? i_ins_key : i_prev.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.entry = r_entry;
    assign o_link.lt    = r_lt;
    assign o_eq         = r_eq;

endmodule

`default_nettype wire

@@ rtl/sorted_set_insert_lookup.sv @@
// the result strobe is registered from the update-phase flag, which the start transfer sets
// a new item waits while busy: busy is high in the cycle after each transfer,
//   while the compare flags are used and, on an insert, cells at and above the insert point shift
// reset: synchronous active-low reset empties the set and clears busy and the strobe
// the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module sorted_set_insert_lookup #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire                  i_action,
    input  wire signed [31:0]    i_key,
    output logic                 o_strobe,
    output logic [2:0]           o_status,
    output logic [5:0]           o_position,
    output logic [6:0]           o_entry_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    logic                 accept;
    logic                 r_ph;
    logic                 r_action;
    ssi_pkg::t_key        r_key;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    ssi_pkg::t_cell_ctl   ctl;
    ssi_pkg::t_cell_link  link [DEPTH];
    ssi_pkg::t_cell_link  prev [DEPTH];
    logic [DEPTH-1:0]     eq;
    logic [DEPTH-1:0]     bnd;
    logic [DEPTH-1:0]     occupied;
    logic [IW-1:0]        pos;
    logic                 present;
    logic                 full;
    ssi_pkg::t_status     status;
    logic                 r_strobe;
    ssi_pkg::t_status     r_status;
    logic [5:0]           r_position;
    logic [6:0]           r_entry_count;
    logic [IW+5:0]        pos_ext;
    logic [CW+6:0]        cnt_ext;

    assign accept = start && !busy;
    assign busy   = r_ph;

    // hold the item for the update cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 1'b0;
        end else begin
            r_ph <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_action;
            r_key    <= i_key;
        end
    end

    // chain of cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign prev[g] = '{entry: '0, lt: 1'b1};
            end else begin : g_rest
                assign prev[g] = link[g-1];
            end
            assign occupied[g] = CW'(g) < r_count;
            assign bnd[g]      = !link[g].lt && prev[g].lt;

            ssi_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_cmp_key  (i_key),
                .i_ins_key  (r_key),
                .i_occupied (occupied[g]),
                .i_prev     (prev[g]),
                .o_link     (link[g]),
                .o_eq       (eq[g])
            );
        end
    endgenerate

    // encode the insert point from the one-hot boundary
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (bnd[i]) begin
                pos = pos | IW'(i);
            end
        end
    end

    assign present = |eq;
    assign full    = r_count == CW'(DEPTH);

    // decide the outcome and whether the chain shifts
    always_comb begin
        ctl.cmp   = accept;
        ctl.shift = 1'b0;
        n_count   = r_count;
        status    = ssi_pkg::ST_ABSENT;
        if (r_ph) begin
            if (r_action == ssi_pkg::ACT_INSERT) begin
                if (present) begin
                    status = ssi_pkg::ST_PRESENT;
                end else if (full) begin
                    status = ssi_pkg::ST_FULL;
                end else begin
                    status    = ssi_pkg::ST_INSERTED;
                    ctl.shift = 1'b1;
                    n_count   = r_count + CW'(1);
                end
            end else begin
                status = present ? ssi_pkg::ST_FOUND : ssi_pkg::ST_ABSENT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register
    assign pos_ext = {6'b0, pos};
    assign cnt_ext = {7'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_ph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ph) begin
            r_status      <= status;
            r_position    <= (status == ssi_pkg::ST_FULL || status == ssi_pkg::ST_ABSENT)
                             ? 6'd0 : pos_ext[5:0];
            r_entry_count <= cnt_ext[6:0];
        end
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

    // every transfer gives exactly one result, strobed after its update cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_strobe)
        else $error("result strobe missing after transfer");

    // the count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // an insert grows the count by exactly one
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.shift |=> r_count == $past(r_count) + CW'(1))
        else $error("count not advanced on insert");

    // a strobe is never raised while an item is still in the update cycle
    a_strobe_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !r_ph)
        else $error("strobe overlaps a pending item");

endmodule

`default_nettype wire

@@ bench/ssi_checker.sv @@
`default_nettype none

module ssi_checker
    import ssi_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_busy,
    input  wire                 i_action,
    input  wire  signed [31:0]  i_key,
    input  wire                 i_strobe,
    input  wire  [2:0]          i_status,
    input  wire  [5:0]          i_position,
    input  wire  [6:0]          i_entry_count,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status              status;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   entry_count;
    } t_set_result;

    // shadow copy of the sorted set
    t_key        set_keys[DEPTH];
    int          set_count;
    t_set_result awaited_results[$];

    // apply one command to the shadow set and work out its result
    task automatic apply_to_set(input logic act, input t_key k, output t_set_result r);
        int  rank;
        logic hit;
        rank = 0;
        for (int i = 0; i < set_count; i++) begin
            if (set_keys[i] < k) begin
                rank++;
            end
        end
        hit = (rank < set_count) && (set_keys[rank] == k);
        r.position = '0;
        if (act == ACT_INSERT) begin
            if (hit) begin
                r.status   = ST_PRESENT;
                r.position = rank[POS_W-1:0];
            end else if (set_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // open a gap at the rank, larger keys move up one place
                for (int i = set_count; i > rank; i--) begin
                    set_keys[i] = set_keys[i-1];
                end
                set_keys[rank] = k;
                set_count++;
                r.status   = ST_INSERTED;
                r.position = rank[POS_W-1:0];
            end
        end else begin
            if (hit) begin
                r.status   = ST_FOUND;
                r.position = rank[POS_W-1:0];
            end else begin
                r.status = ST_ABSENT;
            end
        end
        r.entry_count = set_count[COUNT_W-1:0];
    endtask

    // compare result transfers, then predict for command transfers
    always @(posedge i_clk) begin : watch
        t_set_result want;
        t_set_result got;
        if (!i_rst_n) begin
            set_count = 0;
            awaited_results.delete();
            o_fail_count = 0;
            o_checked = 0;
        end else begin
            if (i_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no command waiting: status %0d position %0d count %0d",
                           i_status, i_position, i_entry_count);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_position !== want.position) begin
                        $error("position: expected %0d, actual %0d", want.position,
                               i_position);
                        o_fail_count++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, actual %0d", want.entry_count,
                               i_entry_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_to_set(i_action, i_key, got);
                awaited_results.push_back(got);
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

`default_nettype wire

@@ bench/sorted_set_insert_lookup_tb.sv @@
`default_nettype none

module sorted_set_insert_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ssi_pkg::*;

    localparam int unsigned DEPTH      = 64;
    localparam int          RANDOM_CNT = 1630;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_action;
    t_key       i_key;
    logic       o_strobe;
    logic [2:0] o_status;
    logic [5:0] o_position;
    logic [6:0] o_entry_count;

    int   fail_count;
    int   pending;
    int   checked;
    int   commands_sent;
    int   inserts_sent;
    int   lookups_sent;
    t_key stored_keys[$];

    sorted_set_insert_lookup #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count)
    );

    ssi_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_action      (i_action),
        .i_key         (i_key),
        .i_strobe      (o_strobe),
        .i_status      (o_status),
        .i_position    (o_position),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // keys already placed, used to steer stimulus toward hits and to report how full the set got
    function automatic bit is_stored(input t_key k);
        foreach (stored_keys[i]) begin
            if (stored_keys[i] == k) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // key mix: held keys, extremes, a narrow band and fully random words
    function automatic t_key pick_key(input int held_weight);
        int sel;
        sel = $urandom_range(99);
        if (sel < held_weight && stored_keys.size() > 0) begin
            return stored_keys[$urandom_range(stored_keys.size() - 1)];
        end
        if (sel < held_weight + 12) begin
            case ($urandom_range(4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        if (sel < held_weight + 30) begin
            return t_key'($signed($urandom_range(16)) - 8);
        end
        return t_key'($urandom());
    endfunction

    // one command transfer; called and returns at a falling edge
    task automatic send_command(input logic act, input t_key k);
        start    <= 1'b1;
        i_action <= act;
        i_key    <= k;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        commands_sent++;
        if (act == ACT_INSERT) begin
            inserts_sent++;
            if (stored_keys.size() < DEPTH && !is_stored(k)) begin
                stored_keys.push_back(k);
            end
        end else begin
            lookups_sent++;
        end
    endtask

    // sender gap, only for n > 0
    task automatic hold_off(input int n);
        start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // stop sending until every result is back
    task automatic drain_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        int   burst_len;
        int   sent;
        int   insert_pct;
        logic act;
        start    = 1'b0;
        i_action = ACT_INSERT;
        i_key    = '0;
        i_rst_n  = 1'b0;
        commands_sent = 0;
        inserts_sent  = 0;
        lookups_sent  = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty set, extremes, smallest key, duplicate, misses
        send_command(ACT_LOOKUP, 32'sd0);
        send_command(ACT_INSERT, 32'sd0);
        send_command(ACT_INSERT, 32'sh7fff_ffff);
        send_command(ACT_INSERT, 32'sh8000_0000);
        send_command(ACT_INSERT, -32'sd1);
        send_command(ACT_INSERT, 32'sd1);
        send_command(ACT_INSERT, 32'sd0);
        send_command(ACT_LOOKUP, 32'sh8000_0000);
        send_command(ACT_LOOKUP, 32'sh7fff_ffff);
        send_command(ACT_LOOKUP, 32'sd5);
        send_command(ACT_INSERT, 32'sh7fff_fffe);
        send_command(ACT_LOOKUP, -32'sd1);
        send_command(ACT_LOOKUP, 32'sh8000_0001);
        send_command(ACT_INSERT, 32'sh5555_5555);
        send_command(ACT_INSERT, t_key'(32'haaaa_aaaa));
        send_command(ACT_INSERT, 32'sh7fff_ffff);
        send_command(ACT_LOOKUP, t_key'(32'haaaa_aaaa));
        send_command(ACT_LOOKUP, 32'sh5555_5554);
        drain_results();

        // random bursts; lookups dominate early so partly filled sets last longer
        sent = 0;
        while (sent < RANDOM_CNT) begin
            burst_len = $urandom_range(1, 40);
            for (int b = 0; b < burst_len && sent < RANDOM_CNT; b++) begin
                insert_pct = (sent < 400) ? 25 : 45;
                act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_LOOKUP;
                send_command(act, pick_key(act == ACT_INSERT ? 20 : 50));
                sent++;
                if (sent == RANDOM_CNT / 2) begin
                    drain_results();
                end
            end
            if ($urandom_range(2) != 0) begin
                hold_off($urandom_range(1, 6));
            end
        end

        // wait out the last results, then keep watching for stray strobes
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (6) @(negedge i_clk);

        $display("tb: %0d commands (%0d inserts, %0d lookups), %0d results checked",
                 commands_sent, inserts_sent, lookups_sent, checked);
        $display("tb: set reached %0d of %0d keys", stored_keys.size(), DEPTH);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/ssi_pkg.sv
rtl/ssi_cell.sv
rtl/sorted_set_insert_lookup.sv
bench/ssi_checker.sv
bench/sorted_set_insert_lookup_tb.sv
